>>> rtl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants for the stepper position controller
// Holds the configuration and result structs, register indexes, half-step
// phase limits and the coil pattern lookup.
// ----------------------------------------------------------------------------
package spc_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_MOTOR_ENABLE = 2'd0,
		REG_MAX_POSITION = 2'd1,
		REG_STEP_PERIOD  = 2'd2
	} reg_idx_t;

	localparam int unsigned FIELD_W = 16;

	// Reset values of the configuration registers
	localparam logic               RST_MOTOR_ENABLE = 1'b1;
	localparam logic [FIELD_W-1:0] RST_MAX_POSITION = 16'd10000;
	localparam logic [FIELD_W-1:0] RST_STEP_PERIOD  = 16'd195;

	// Half-step phase range; phase 0 drives no coils
	localparam logic [3:0] PHASE_IDLE  = 4'd0;
	localparam logic [3:0] PHASE_FIRST = 4'd1;
	localparam logic [3:0] PHASE_LAST  = 4'd8;

	typedef struct packed {
		logic               motor_enable;
		logic [FIELD_W-1:0] max_position;
		logic [FIELD_W-1:0] step_period;
	} cfg_t;

	typedef struct packed {
		logic               target_rejected;
		logic               step_taken;
		logic               direction;
		logic               at_target;
		logic [FIELD_W-1:0] position;
		logic [3:0]         coil_pattern;
	} res_t;

	// Coil drive bits for each half-step phase
	function automatic logic [3:0] coil_of(input logic [3:0] ph);
		logic [3:0] c;
		case (ph)
			4'd1:    c = 4'h1;
			4'd2:    c = 4'h5;
			4'd3:    c = 4'h4;
			4'd4:    c = 4'h6;
			4'd5:    c = 4'h2;
			4'd6:    c = 4'hA;
			4'd7:    c = 4'h8;
			4'd8:    c = 4'h9;
			default: c = 4'h0;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/stepper_position_controller.sv
// ----------------------------------------------------------------------------
// stepper_position_controller: half-step stepper drive with position control
// Accepts timer ticks and target requests, steps a four-coil motor toward
// the target and reports coils, position and status for every request.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle while the output side keeps
// taking results, and each gives exactly one result. A request is
// registered on transfer, the step decision (a compare and a one-count move
// of position and phase) runs in the motion core once the output register
// is free, and the result is registered in the output register and held
// there until it transfers out. Sustained rate is one request per cycle while
// the output side keeps taking results; a stalled output holds the result
// and back-pressures the input. Registers are written through
// cfg_we/cfg_addr/cfg_wdata and should change only while no request is in
// flight.
module stepper_position_controller #(
	parameter int unsigned POS_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration writes
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_addr,
	input  logic [spc_pkg::FIELD_W-1:0]   cfg_wdata,
	// request stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,   // [15:0] new_target
	input  logic                          s_tuser,   // [0] req_type
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [3:0] coil_pattern, [19:4] position, [20] at_target, [21] direction,
	// [22] step_taken, [23] target_rejected
	output logic [23:0]                   m_tdata
);
	import spc_pkg::*;

	cfg_t               cfg_q;
	logic               valid_s1;
	logic               req_type_s1;
	logic [FIELD_W-1:0] new_target_s1;
	logic               valid_s2;
	res_t               res_s2;
	res_t               res;
	logic               adv;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.motor_enable <= RST_MOTOR_ENABLE;
			cfg_q.max_position <= RST_MAX_POSITION;
			cfg_q.step_period  <= RST_STEP_PERIOD;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MOTOR_ENABLE: cfg_q.motor_enable <= cfg_wdata[0];
				REG_MAX_POSITION: cfg_q.max_position <= cfg_wdata;
				REG_STEP_PERIOD:  cfg_q.step_period  <= cfg_wdata;
				default:          ;
			endcase
		end
	end

	// Advance the request into the result register when it is free
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_type_s1   <= s_tuser;
			new_target_s1 <= s_tdata;
		end
	end

	spc_motion #(
		.POS_WIDTH (POS_WIDTH)
	) u_motion (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (adv),
		.req_type   (req_type_s1),
		.new_target (new_target_s1),
		.cfg        (cfg_q),
		.res        (res)
	);

	// Hold the result until the output side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2;

`ifndef ASSERT_OFF
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !m_tready |-> !adv)
		else $error("result register overwritten while stalled");

	a_stage_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(req_type_s1) && $stable(new_target_s1))
		else $error("pending request lost from input stage");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.step_taken && res_s2.target_rejected))
		else $error("result both stepped and rejected a target");
`endif

endmodule

>>> rtl/spc_motion.sv
// ----------------------------------------------------------------------------
// spc_motion: motion state and step decision
// Holds position, target, phase and tick count, and works out the next
// state and the result of one request combinationally.
// ----------------------------------------------------------------------------
module spc_motion #(
	parameter int unsigned POS_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic                          req_type,
	input  logic [spc_pkg::FIELD_W-1:0]   new_target,
	input  spc_pkg::cfg_t                 cfg,
	output spc_pkg::res_t                 res
);
	import spc_pkg::*;

	localparam int unsigned EXT_W = (POS_WIDTH > FIELD_W) ? POS_WIDTH : FIELD_W;

	logic [POS_WIDTH-1:0] pos_q, pos_d;
	logic [POS_WIDTH-1:0] target_q, target_d;
	logic [3:0]           phase_q, phase_d;
	logic [FIELD_W-1:0]   tick_q, tick_d;
	logic                 reached_q, reached_d;
	logic                 dir_q, dir_d;

	logic [FIELD_W:0]     tick_next;
	logic                 fire;
	logic                 tgt_ok;
	logic                 fwd;
	logic                 stepped;
	logic [EXT_W-1:0]     pos_ext;

	// Range checks for a new target and for the forward move
	assign tgt_ok = new_target < cfg.max_position;
	assign fwd    = (pos_q < target_q) && (EXT_W'(target_q) < EXT_W'(cfg.max_position));
	assign tick_next = {1'b0, tick_q} + (FIELD_W+1)'(1);
	assign fire      = !req_type && (tick_next >= {1'b0, cfg.step_period});

	// Next state for one request
	always_comb begin
		pos_d     = pos_q;
		target_d  = target_q;
		phase_d   = phase_q;
		tick_d    = tick_q;
		reached_d = reached_q;
		dir_d     = dir_q;
		stepped   = 1'b0;
		if (req_type) begin
			if (tgt_ok) begin
				target_d = POS_WIDTH'(new_target);
			end
		end else if (!fire) begin
			tick_d = tick_next[FIELD_W-1:0];
		end else begin
			tick_d = '0;
			if (cfg.motor_enable) begin
				if (pos_q == target_q) begin
					reached_d = 1'b1;
				end else begin
					reached_d = 1'b0;
					stepped   = 1'b1;
					if (fwd) begin
						dir_d   = 1'b1;
						phase_d = (phase_q >= PHASE_LAST) ? PHASE_FIRST : phase_q + 4'd1;
						pos_d   = pos_q + POS_WIDTH'(1);
					end else begin
						dir_d   = 1'b0;
						phase_d = (phase_q <= PHASE_FIRST || phase_q > PHASE_LAST) ?
							PHASE_LAST : phase_q - 4'd1;
						pos_d   = pos_q - POS_WIDTH'(1);
					end
				end
			end
		end
	end

	// Result reflects the state after this request
	assign pos_ext = EXT_W'(pos_d);
	always_comb begin
		res.coil_pattern    = coil_of(phase_d);
		res.position        = pos_ext[FIELD_W-1:0];
		res.at_target       = reached_d;
		res.direction       = dir_d;
		res.step_taken      = stepped;
		res.target_rejected = req_type && !tgt_ok;
	end

	// Commit the state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			target_q  <= '0;
			phase_q   <= PHASE_IDLE;
			tick_q    <= '0;
			reached_q <= 1'b0;
			dir_q     <= 1'b0;
		end else if (go) begin
			pos_q     <= pos_d;
			target_q  <= target_d;
			phase_q   <= phase_d;
			tick_q    <= tick_d;
			reached_q <= reached_d;
			dir_q     <= dir_d;
		end
	end

`ifndef ASSERT_OFF
	a_target_keeps_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		go && req_type |=> $stable(tick_q) && $stable(pos_q) && $stable(phase_q))
		else $error("target request disturbed tick count or motion state");

	a_step_moves: assert property (@(posedge clk) disable iff (!arst_n)
		go && res.step_taken |=> (pos_q != $past(pos_q)) && (phase_q != PHASE_IDLE))
		else $error("step taken without moving position and phase");

	a_disabled_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		go && !cfg.motor_enable |=> $stable(pos_q) && $stable(phase_q) && $stable(reached_q))
		else $error("motion state changed while motor disabled");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PHASE_LAST)
		else $error("phase left the half-step sequence");
`endif

endmodule
